// File: hdl/tsd_pkg.sv
// ---------------------------------------------------------------------------
// tsd_pkg: shared types and constants of the trie string dictionary
// Operation and status codes, controller states and default sizes.
// ---------------------------------------------------------------------------
package tsd_pkg;

  localparam int NODE_COUNT_DEF    = 1024;
  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int MAX_WORD_LEN_DEF  = 64;

  localparam int KIND_W   = 2;
  localparam int LETTER_W = 5;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 16;

  localparam logic [COUNT_W-1:0] END_MAX = '1;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_SEARCH = 2'd1,
    KIND_DELETE = 2'd2,
    KIND_ALT    = 2'd3
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_DONE      = 2'd0,
    STAT_NOT_FOUND = 2'd1,
    STAT_POOL_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOK,
    ST_FIN,
    ST_DONE,
    ST_UNW_POP,
    ST_UNW_CUT,
    ST_UNW_DEC
  } state_t;

endpackage

// File: hdl/tsd_ram.sv
// ---------------------------------------------------------------------------
// tsd_ram: generic single-clock ram
// One write port, one read port, read data registered and held when idle.
// ---------------------------------------------------------------------------
module tsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: hdl/trie_string_dictionary_core.sv
// A letter reads the child table on acceptance, then ST_LOOK links or allocates the child;
// after a failed walk it is only accepted. The final letter adds ST_FIN (node table read)
// and ST_DONE (end count update). A delete that empties a word unwinds each unlinked level
// in ST_UNW_POP (path stack read), ST_UNW_CUT (child table clear) and ST_UNW_DEC (parent
// child count update). New letters are taken only in ST_IDLE, after the dependent child
// table read. Reset: synchronous; a clearing pass zeroes the child and node tables.
// ---------------------------------------------------------------------------
// trie_string_dictionary_core: array-indexed trie dictionary
// Insert, search and delete of words fed one letter per transaction.
// ---------------------------------------------------------------------------
module trie_string_dictionary_core
  import tsd_pkg::*;
#(
  parameter int NODE_COUNT    = NODE_COUNT_DEF,
  parameter int ALPHABET_SIZE = ALPHABET_SIZE_DEF,
  parameter int MAX_WORD_LEN  = MAX_WORD_LEN_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [KIND_W-1:0]   kind,
  input  logic [LETTER_W-1:0] letter,
  input  logic                last_letter,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [KIND_W-1:0]   op_kind,
  output logic [STATUS_W-1:0] status,
  output logic [COUNT_W-1:0]  end_count
);

  localparam int NW       = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
  localparam int FW       = NW + 1;
  localparam int CT_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int CAW      = (CT_DEPTH > 1) ? $clog2(CT_DEPTH) : 1;
  localparam int CCW      = $clog2(ALPHABET_SIZE + 1);
  localparam int NDW      = COUNT_W + CCW;
  localparam int PW       = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
  localparam int DW       = $clog2(MAX_WORD_LEN + 2);
  localparam int SW       = NW + LETTER_W;

  state_t state, state_next;

  logic [CAW-1:0]      clr;
  logic [NW-1:0]       walk_node;
  logic [FW-1:0]       next_free;
  logic [DW-1:0]       depth;
  status_t             failed;
  kind_t               cur_kind;
  logic [LETTER_W-1:0] cur_letter;
  logic                cur_last;
  logic [DW-1:0]       unw_i;

  // memory ports
  logic           ct_we, ct_re;
  logic [CAW-1:0] ct_waddr, ct_raddr;
  logic [NW-1:0]  ct_wdata, ct_rdata;
  logic           nd_we, nd_re;
  logic [NW-1:0]  nd_waddr, nd_raddr;
  logic [NDW-1:0] nd_wdata, nd_rdata;
  logic           ps_we, ps_re;
  logic [PW-1:0]  ps_waddr, ps_raddr;
  logic [SW-1:0]  ps_wdata, ps_rdata;

  tsd_ram #(.WIDTH(NW), .DEPTH(CT_DEPTH)) u_child (
    .clk(clk), .we(ct_we), .waddr(ct_waddr), .wdata(ct_wdata),
    .re(ct_re), .raddr(ct_raddr), .rdata(ct_rdata)
  );

  tsd_ram #(.WIDTH(NDW), .DEPTH(NODE_COUNT)) u_node (
    .clk(clk), .we(nd_we), .waddr(nd_waddr), .wdata(nd_wdata),
    .re(nd_re), .raddr(nd_raddr), .rdata(nd_rdata)
  );

  tsd_ram #(.WIDTH(SW), .DEPTH(MAX_WORD_LEN)) u_path (
    .clk(clk), .we(ps_we), .waddr(ps_waddr), .wdata(ps_wdata),
    .re(ps_re), .raddr(ps_raddr), .rdata(ps_rdata)
  );

  // decoded fields
  logic                in_acc;
  kind_t               in_kind;
  logic                bad_letter;
  logic [COUNT_W-1:0]  nd_end;
  logic [CCW-1:0]      nd_cc;
  logic [NW-1:0]       ps_parent;
  logic [LETTER_W-1:0] ps_letter;
  logic                out_free;
  logic                depth_ok;
  logic                del_ok;
  logic [COUNT_W-1:0]  del_end;
  logic [COUNT_W-1:0]  ins_end;
  logic                unw_start;
  logic [CCW-1:0]      dec_cc;
  logic                unw_more;
  logic                pool_empty;
  logic                walk_clear;

  assign in_acc     = in_valid && in_ready;
  assign in_kind    = (kind == KIND_ALT) ? KIND_SEARCH : kind_t'(kind);
  assign bad_letter = ({2'b00, letter} >= 7'(ALPHABET_SIZE));
  assign nd_end     = nd_rdata[NDW-1:CCW];
  assign nd_cc      = nd_rdata[CCW-1:0];
  assign ps_parent  = ps_rdata[SW-1:LETTER_W];
  assign ps_letter  = ps_rdata[LETTER_W-1:0];
  assign out_free   = !out_valid || out_ready;
  assign depth_ok   = (depth <= DW'(MAX_WORD_LEN));
  assign del_ok     = (failed == STAT_DONE) && depth_ok && (nd_end != '0);
  assign del_end    = nd_end - COUNT_W'(1);
  assign ins_end    = (nd_end == END_MAX) ? nd_end : nd_end + COUNT_W'(1);
  assign unw_start  = del_ok && (del_end == '0) && (nd_cc == '0) &&
                      (walk_node != '0) && (depth != '0);
  assign dec_cc     = (nd_cc == '0) ? nd_cc : nd_cc - CCW'(1);
  assign unw_more   = (unw_i != '0) && (ps_parent != '0) && (nd_end == '0) &&
                      (dec_cc == '0);
  assign pool_empty = (next_free >= FW'(NODE_COUNT));
  assign in_ready   = (state == ST_IDLE);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr == CAW'(CT_DEPTH - 1)) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          if (failed != STAT_DONE || bad_letter) begin
            state_next = last_letter ? ST_FIN : ST_IDLE;
          end else begin
            state_next = ST_LOOK;
          end
        end
      end
      ST_LOOK:    state_next = cur_last ? ST_FIN : ST_IDLE;
      ST_FIN:     state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          if (cur_kind == KIND_DELETE && unw_start) state_next = ST_UNW_POP;
          else state_next = ST_IDLE;
        end
      end
      ST_UNW_POP: state_next = ST_UNW_CUT;
      ST_UNW_CUT: state_next = ST_UNW_DEC;
      ST_UNW_DEC: state_next = unw_more ? ST_UNW_POP : ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  // memory control
  always_comb begin
    ct_we      = 1'b0;
    ct_waddr   = '0;
    ct_wdata   = '0;
    ct_re      = 1'b0;
    ct_raddr   = CAW'(walk_node) * CAW'(ALPHABET_SIZE) + CAW'(letter);
    nd_we      = 1'b0;
    nd_waddr   = walk_node;
    nd_wdata   = '0;
    nd_re      = 1'b0;
    nd_raddr   = walk_node;
    ps_we      = 1'b0;
    ps_waddr   = depth[PW-1:0];
    ps_wdata   = {walk_node, cur_letter};
    ps_re      = 1'b0;
    ps_raddr   = PW'(unw_i - DW'(1));
    walk_clear = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        ct_we    = 1'b1;
        ct_waddr = clr;
        nd_we    = (clr < CAW'(NODE_COUNT));
        nd_waddr = clr[NW-1:0];
      end
      ST_IDLE: begin
        ct_re = in_acc && (failed == STAT_DONE) && !bad_letter;
        nd_re = ct_re;
      end
      ST_LOOK: begin
        if (ct_rdata == '0 && cur_kind == KIND_INSERT && !pool_empty) begin
          ct_we    = 1'b1;
          ct_waddr = CAW'(walk_node) * CAW'(ALPHABET_SIZE) + CAW'(cur_letter);
          ct_wdata = next_free[NW-1:0];
          nd_we    = 1'b1;
          nd_wdata = {nd_end, nd_cc + CCW'(1)};
        end
        ps_we = (ct_rdata != '0 || (cur_kind == KIND_INSERT && !pool_empty)) &&
                (depth < DW'(MAX_WORD_LEN));
      end
      ST_FIN: begin
        nd_re = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          walk_clear = !(cur_kind == KIND_DELETE && unw_start);
          if (cur_kind == KIND_INSERT && failed == STAT_DONE) begin
            nd_we    = 1'b1;
            nd_wdata = {ins_end, nd_cc};
          end else if (cur_kind == KIND_DELETE && del_ok) begin
            nd_we    = 1'b1;
            nd_wdata = {del_end, nd_cc};
          end
        end
      end
      ST_UNW_POP: begin
        ps_re = 1'b1;
      end
      ST_UNW_CUT: begin
        ct_we    = 1'b1;
        ct_waddr = CAW'(ps_parent) * CAW'(ALPHABET_SIZE) + CAW'(ps_letter);
        nd_re    = 1'b1;
        nd_raddr = ps_parent;
      end
      ST_UNW_DEC: begin
        nd_we      = 1'b1;
        nd_waddr   = ps_parent;
        nd_wdata   = {nd_end, dec_cc};
        walk_clear = !unw_more;
      end
      default: ;
    endcase
  end

  // controller registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr       <= '0;
      walk_node <= '0;
      next_free <= FW'(1);
      depth     <= '0;
      failed    <= STAT_DONE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr <= clr + CAW'(1);

      // letter transaction
      if (state == ST_IDLE && in_acc && failed == STAT_DONE && bad_letter) begin
        failed <= STAT_NOT_FOUND;
      end

      // child lookup result
      if (state == ST_LOOK) begin
        if (ct_rdata == '0 && cur_kind != KIND_INSERT) begin
          failed <= STAT_NOT_FOUND;
        end else if (ct_rdata == '0 && pool_empty) begin
          failed <= STAT_POOL_FULL;
        end else begin
          if (ct_rdata == '0) begin
            walk_node <= next_free[NW-1:0];
            next_free <= next_free + FW'(1);
          end else begin
            walk_node <= ct_rdata;
          end
          if (depth < DW'(MAX_WORD_LEN)) depth <= depth + DW'(1);
          else depth <= DW'(MAX_WORD_LEN + 1);
        end
      end

      // result of the word
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      if (walk_clear) begin
        walk_node <= '0;
        depth     <= '0;
        failed    <= STAT_DONE;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cur_kind   <= in_kind;
      cur_letter <= letter;
      cur_last   <= last_letter;
    end
    if (state == ST_DONE && out_free) begin
      op_kind   <= cur_kind;
      status    <= STAT_NOT_FOUND;
      end_count <= '0;
      unw_i     <= depth;
      unique case (cur_kind)
        KIND_INSERT: begin
          if (failed == STAT_DONE) begin
            status    <= STAT_DONE;
            end_count <= ins_end;
          end else begin
            status    <= failed;
          end
        end
        KIND_DELETE: begin
          if (del_ok) begin
            status    <= STAT_DONE;
            end_count <= del_end;
          end
        end
        default: begin
          if (failed == STAT_DONE && nd_end != '0) begin
            status    <= STAT_DONE;
            end_count <= nd_end;
          end
        end
      endcase
    end
    if (state == ST_UNW_POP) unw_i <= unw_i - DW'(1);
  end

endmodule

// File: hdl/tsd_checker.sv
// ---------------------------------------------------------------------------
// tsd_checker: port-level assertions of the trie dictionary
// Watches the result channel and its status encoding.
// ---------------------------------------------------------------------------
module tsd_checker
  import tsd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input logic [KIND_W-1:0]   op_kind,
  input logic [STATUS_W-1:0] status,
  input logic [COUNT_W-1:0]  end_count
);

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(end_count))
    else $error("result changed while stalled");

  // failure never reports a count
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STAT_DONE |-> end_count == '0)
    else $error("failed operation with nonzero count");

  // successful insert or search leaves at least one copy
  a_found_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_DONE && op_kind != KIND_DELETE |-> end_count != '0)
    else $error("found word with zero count");

  // pool full only on insert
  a_pool_insert: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STAT_POOL_FULL |-> op_kind == KIND_INSERT)
    else $error("pool full on non-insert");

  // reported kind and status are legal codes
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> op_kind != KIND_ALT && status != 2'd3)
    else $error("illegal result code");

endmodule

bind trie_string_dictionary_core tsd_checker u_tsd_checker (
  .clk(clk), .rst(rst), .out_valid(out_valid), .out_ready(out_ready),
  .op_kind(op_kind), .status(status), .end_count(end_count)
);

// File: tb/tb_trie_string_dictionary_core.sv
// ---------------------------------------------------------------------------
// tb_trie_string_dictionary_core: self-checking testbench of the trie core
// Words go in one letter per transaction. A trie model inside the bench
// predicts every result, and the bench compares each result in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_trie_string_dictionary_core;
  import tsd_pkg::*;

  localparam int NODES = NODE_COUNT_DEF;
  localparam int ALPHA = ALPHABET_SIZE_DEF;
  localparam int MAXLEN = MAX_WORD_LEN_DEF;

  // idle modes
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SEND = 1;
  localparam int IDLE_RECV = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct {
    int op;
    int stat;
    int cnt;
  } word_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [KIND_W-1:0] kind = KIND_INSERT;
  logic [LETTER_W-1:0] letter = '0;
  logic last_letter = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [KIND_W-1:0] op_kind;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0] end_count;

  int idle_mode = IDLE_NONE;
  int hold_left = 0;
  int err_count = 0;
  word_result_t pending_results[$];

  // trie model state
  int t_child[NODES*ALPHA];
  int t_ends[NODES];
  int t_kids[NODES];
  int t_next;
  int t_node;
  int t_pnode[MAXLEN];
  int t_pletter[MAXLEN];
  int t_depth;
  int t_failed;

  trie_string_dictionary_core DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .kind(kind), .letter(letter), .last_letter(last_letter),
    .out_valid(out_valid), .out_ready(out_ready),
    .op_kind(op_kind), .status(status), .end_count(end_count)
  );

  always #6 clk = ~clk;

  initial begin
    #(12.0 * 3000000);
    $display("Some tests failed");
    $finish;
  end

  // receiver: long hold first, then stall pattern of the current mode
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (idle_mode == IDLE_RECV) begin
      out_ready <= ($urandom_range(99) >= 87);
    end else if (idle_mode == IDLE_BOTH) begin
      out_ready <= ($urandom_range(99) >= 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    err_count++;
  endtask

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    word_result_t w;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result, op_kind", op_kind, -1);
      end else begin
        w = pending_results.pop_front();
        if (op_kind != w.op) report_mismatch("op_kind", op_kind, w.op);
        if (status != w.stat) report_mismatch("status", status, w.stat);
        if (end_count != w.cnt) report_mismatch("end_count", end_count, w.cnt);
      end
    end
  end

  // trie model: one letter, queues a result on the final letter
  task automatic trie_step(input int k_in, input int l, input bit fin);
    int k, slot, ch, node, i, par;
    word_result_t w;
    k = (k_in == KIND_ALT) ? KIND_SEARCH : k_in;
    // walk one level
    if (t_failed == STAT_DONE) begin
      if (l >= ALPHA) begin
        t_failed = STAT_NOT_FOUND;
      end else begin
        slot = t_node * ALPHA + l;
        ch = t_child[slot];
        if (ch == 0) begin
          if (k != KIND_INSERT) t_failed = STAT_NOT_FOUND;
          else if (t_next >= NODES) t_failed = STAT_POOL_FULL;
          else begin
            ch = t_next;
            t_next++;
            t_child[slot] = ch;
            t_kids[t_node]++;
          end
        end
        if (t_failed == STAT_DONE) begin
          if (t_depth < MAXLEN) begin
            t_pnode[t_depth] = t_node;
            t_pletter[t_depth] = l;
            t_depth++;
          end else begin
            t_depth = MAXLEN + 1;
          end
          t_node = ch;
        end
      end
    end
    if (!fin) return;
    // finish the word
    w.op = k;
    w.stat = STAT_NOT_FOUND;
    w.cnt = 0;
    if (k == KIND_INSERT) begin
      if (t_failed == STAT_DONE) begin
        if (t_ends[t_node] < 65535) t_ends[t_node]++;
        w.stat = STAT_DONE;
        w.cnt = t_ends[t_node];
      end else begin
        w.stat = t_failed;
      end
    end else if (k == KIND_SEARCH) begin
      if (t_failed == STAT_DONE && t_ends[t_node] != 0) begin
        w.stat = STAT_DONE;
        w.cnt = t_ends[t_node];
      end
    end else if (t_failed == STAT_DONE && t_depth <= MAXLEN && t_ends[t_node] != 0) begin
      t_ends[t_node]--;
      w.stat = STAT_DONE;
      w.cnt = t_ends[t_node];
      // unlink dead nodes up the path
      node = t_node;
      i = t_depth;
      while (i > 0 && node != 0 && t_ends[node] == 0 && t_kids[node] == 0) begin
        i--;
        par = t_pnode[i];
        t_child[par * ALPHA + t_pletter[i]] = 0;
        if (t_kids[par] != 0) t_kids[par]--;
        node = par;
      end
    end
    pending_results.insert(pending_results.size(), w);
    t_node = 0;
    t_depth = 0;
    t_failed = STAT_DONE;
  endtask

  // offer one letter, wait for acceptance, then predict
  task automatic send_letter(input int k, input int l, input bit fin);
    int p;
    p = (idle_mode == IDLE_SEND) ? 87 : (idle_mode == IDLE_BOTH) ? 11 : 0;
    @(negedge clk);
    while ($urandom_range(99) < p) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    kind = k;
    letter = l;
    last_letter = fin;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    trie_step(k, l, fin);
  endtask

  task automatic send_word(input int k, input int w[$]);
    foreach (w[i]) send_letter(k, w[i], i == w.size() - 1);
  endtask

  // sender pauses until every prediction has been met
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic test_directed();
    idle_mode = IDLE_NONE;
    send_word(KIND_INSERT, '{0, 1});
    send_word(KIND_INSERT, '{0, 1});
    send_word(KIND_SEARCH, '{0, 1});
    send_word(KIND_SEARCH, '{0});            // prefix only
    send_word(KIND_SEARCH, '{0, 1, 2});      // missing
    send_word(KIND_DELETE, '{0, 1});
    send_word(KIND_DELETE, '{0, 1});
    send_word(KIND_DELETE, '{0, 1});         // already gone
    send_word(KIND_INSERT, '{25});
    send_word(KIND_INSERT, '{31});           // letter out of range
    send_word(KIND_ALT, '{25});              // kind three searches
    send_letter(KIND_INSERT, 3, 1'b0);       // mixed kinds in one word
    send_letter(KIND_SEARCH, 4, 1'b1);
    send_letter(KIND_INSERT, 5, 1'b0);
    send_letter(KIND_DELETE, 6, 1'b1);
    drain();
  endtask

  // words beyond the path stack: delete is refused; a word that just fits is deleted
  task automatic test_long_word();
    int w[$];
    for (int i = 0; i < MAXLEN + 3; i++) w = {w, i % 3};
    send_word(KIND_INSERT, w);
    send_word(KIND_SEARCH, w);
    send_word(KIND_DELETE, w);
    send_word(KIND_SEARCH, w);
    w = {};
    for (int i = 0; i < MAXLEN; i++) w = {w, 7};
    send_word(KIND_INSERT, w);
    send_word(KIND_DELETE, w);
    drain();
  endtask

  // random words over a small alphabet so that they collide often
  task automatic random_word();
    int w[$], len, k, r;
    r = $urandom_range(99);
    k = (r < 45) ? KIND_INSERT : (r < 72) ? KIND_SEARCH : (r < 95) ? KIND_DELETE : KIND_ALT;
    len = $urandom_range(1, 4);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 3) w = {w, int'($urandom_range(31))};
      else w = {w, int'($urandom_range(3))};
    end
    if ($urandom_range(99) < 6) begin
      foreach (w[i]) send_letter($urandom_range(3), w[i], i == w.size() - 1);
    end else begin
      send_word(k, w);
    end
  endtask

  task automatic test_random(input int mode, input int nwords);
    idle_mode = mode;
    repeat (nwords) random_word();
    drain();
  endtask

  // receiver holds off while the sender keeps offering
  task automatic test_backpressure();
    idle_mode = IDLE_NONE;
    hold_left = 400;
    repeat (40) random_word();
    drain();
  endtask

  // repeated inserts of one word raise its end count
  task automatic test_repeat_insert();
    idle_mode = IDLE_NONE;
    repeat (40) send_letter(KIND_INSERT, 16, 1'b1);
    send_word(KIND_SEARCH, '{16});
    send_word(KIND_DELETE, '{16});
    drain();
  endtask

  // run the node pool dry, then check what is left
  task automatic test_pool_full();
    int w[$];
    idle_mode = IDLE_BOTH;
    repeat (30) begin
      w = {};
      for (int i = 0; i < 30; i++) w = {w, int'($urandom_range(25))};
      send_word(KIND_INSERT, w);
    end
    repeat (20) random_word();
    drain();
  endtask

  initial begin
    t_next = 1;
    t_node = 0;
    t_depth = 0;
    t_failed = STAT_DONE;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_long_word();
    test_random(IDLE_NONE, 25);
    test_random(IDLE_SEND, 25);
    test_random(IDLE_RECV, 25);
    test_random(IDLE_BOTH, 25);
    test_backpressure();
    test_repeat_insert();
    test_pool_full();
    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/tsd_pkg.sv
hdl/tsd_ram.sv
hdl/trie_string_dictionary_core.sv
hdl/tsd_checker.sv
tb/tb_trie_string_dictionary_core.sv
